// ----- rtl/core/sess_tbl_pkg.sv -----
// ----------------------------------------------------------------------------
// sess_tbl_pkg
// Types and codes shared by the session table and its slot cells.
// ----------------------------------------------------------------------------
package sess_tbl_pkg;

    localparam int SLOT_IDX_W = 6;
    localparam int FREE_W     = 7;

    localparam logic [1:0] MODE_STORE  = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_NONE        = 2'd0;
    localparam logic [1:0] ST_ESTABLISHED = 2'd2;

    localparam logic [2:0] STATUS_EXISTING  = 3'd0;
    localparam logic [2:0] STATUS_NEW_SLOT  = 3'd1;
    localparam logic [2:0] STATUS_NO_SPACE  = 3'd2;
    localparam logic [2:0] STATUS_REMOVED   = 3'd3;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STATUS_OLDEST    = 3'd5;
    localparam logic [2:0] STATUS_NONE_EST  = 3'd6;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [15:0] netif;
    } key_t;

    // search word handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  match_hit;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic [1:0]            match_state;
        logic                  empty_hit;
        logic [SLOT_IDX_W-1:0] empty_idx;
        logic                  best_hit;
        logic [SLOT_IDX_W-1:0] best_idx;
        logic [63:0]           best_stamp;
        key_t                  best_key;
    } token_t;

    // write-back broadcast to all cells
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  wr_key;
        key_t                  key;
        logic                  wr_state;
        logic [1:0]            state;
        logic                  wr_stamp;
        logic [63:0]           stamp;
    } wr_cmd_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [1:0]            previous_state;
        logic [SLOT_IDX_W-1:0] slot_index;
        key_t                  found;
        logic [FREE_W-1:0]     free_slots;
    } res_t;

endpackage

// ----- rtl/core/sess_tbl_cell.sv -----
// ----------------------------------------------------------------------------
// sess_tbl_cell
// One table slot: holds key, state and stamp, folds itself into the search
// word and passes it on to the next cell.
// ----------------------------------------------------------------------------
module sess_tbl_cell import sess_tbl_pkg::*; #(
    parameter int CELL_INDEX = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  key_t    req_key,
    input  token_t  tok_in,
    input  wr_cmd_t wr,
    output token_t  tok_out
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

    key_t        key_reg;
    logic [1:0]  state_reg;
    logic [63:0] stamp_reg;
    token_t      tok_reg;
    token_t      tok_next;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid) begin
            if (!tok_in.match_hit && (key_reg == req_key)) begin
                tok_next.match_hit   = 1'b1;
                tok_next.match_idx   = MY_IDX;
                tok_next.match_state = state_reg;
            end
            if (state_reg == ST_NONE) begin
                tok_next.empty_hit = 1'b1;
                tok_next.empty_idx = MY_IDX;
            end
            if ((state_reg == ST_ESTABLISHED) &&
                (!tok_in.best_hit || (tok_in.best_stamp > stamp_reg))) begin
                tok_next.best_hit   = 1'b1;
                tok_next.best_idx   = MY_IDX;
                tok_next.best_stamp = stamp_reg;
                tok_next.best_key   = key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            key_reg   <= '0;
            state_reg <= ST_NONE;
            stamp_reg <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr.en && (wr.idx == MY_IDX)) begin
                if (wr.wr_key) begin
                    key_reg <= wr.key;
                end
                if (wr.wr_state) begin
                    state_reg <= wr.state;
                end
                if (wr.wr_stamp) begin
                    stamp_reg <= wr.stamp;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/core/session_table_with_oldest_search.sv -----
// ----------------------------------------------------------------------------
// session_table_with_oldest_search
// Peer session table with store, remove and oldest-established query.
// ----------------------------------------------------------------------------
// One word is handled at a time. The accepting edge registers the request, and
// the search word then steps through the row of slot cells, registered in each
// cell. At the end of the row the decision is made, written back into the chosen
// cell and registered as the result, which is then loaded into the output
// register once the result side is free. A new word is accepted only after the
// result has been loaded into the output register. The table is cleared by
// reset directly, with no clearing pass.
module session_table_with_oldest_search import sess_tbl_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_key_addr_high,
    input  logic [63:0] s_key_addr_low,
    input  logic [15:0] s_key_port,
    input  logic [15:0] s_key_netif,
    input  logic [1:0]  s_store_state,
    input  logic [63:0] s_time_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_previous_state,
    output logic [5:0]  m_slot_index,
    output logic [63:0] m_found_addr_high,
    output logic [63:0] m_found_addr_low,
    output logic [15:0] m_found_port,
    output logic [15:0] m_found_netif,
    output logic [6:0]  m_free_slots
);

    localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_WAIT   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        mode_reg;
    key_t              key_reg;
    logic [1:0]        nst_reg;
    logic [63:0]       now_reg;
    logic              start_reg;
    logic [FREE_W-1:0] free_reg, free_next;
    res_t              res_reg, res_next;
    res_t              out_reg;
    logic              m_valid_reg;
    wr_cmd_t           wr;
    token_t            chain [SLOT_COUNT+1];
    logic [SLOT_COUNT:0] chain_valid;
    token_t            tail;
    logic              accept;
    logic              done;
    logic              load_out;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign tail     = chain[SLOT_COUNT];
    assign done     = (state_reg == S_SEARCH) && tail.valid;
    assign load_out = (state_reg == S_WAIT) && (!m_valid_reg || m_ready);

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
            sess_tbl_cell #(
                .CELL_INDEX(gi)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .req_key (key_reg),
                .tok_in  (chain[gi]),
                .wr      (wr),
                .tok_out (chain[gi+1])
            );
        end
        for (gi = 0; gi <= SLOT_COUNT; gi++) begin : g_valid
            assign chain_valid[gi] = chain[gi].valid;
        end
    endgenerate

    // decision and write-back at the end of the row
    always_comb begin
        wr                        = '0;
        wr.key                    = key_reg;
        wr.state                  = nst_reg;
        wr.stamp                  = now_reg;
        free_next                 = free_reg;
        res_next                  = '0;
        res_next.status           = STATUS_NOT_FOUND;
        case (mode_reg)
            MODE_STORE: begin
                if (tail.match_hit) begin
                    wr.en                   = done;
                    wr.idx                  = tail.match_idx;
                    wr.wr_state             = (tail.match_state != ST_ESTABLISHED);
                    wr.wr_stamp             = 1'b1;
                    res_next.status         = STATUS_EXISTING;
                    res_next.previous_state = tail.match_state;
                    res_next.slot_index     = tail.match_idx;
                end else if (tail.empty_hit) begin
                    wr.en               = done;
                    wr.idx              = tail.empty_idx;
                    wr.wr_key           = 1'b1;
                    wr.wr_state         = 1'b1;
                    wr.wr_stamp         = 1'b1;
                    res_next.status     = STATUS_NEW_SLOT;
                    res_next.slot_index = tail.empty_idx;
                    if (free_reg != '0) begin
                        free_next = free_reg - FREE_W'(1);
                    end
                end else begin
                    res_next.status = STATUS_NO_SPACE;
                end
            end
            MODE_REMOVE: begin
                if (tail.match_hit) begin
                    wr.en               = done;
                    wr.idx              = tail.match_idx;
                    wr.wr_key           = 1'b1;
                    wr.key              = '0;
                    wr.wr_state         = 1'b1;
                    wr.state            = ST_NONE;
                    res_next.status     = STATUS_REMOVED;
                    res_next.slot_index = tail.match_idx;
                    if (free_reg < FREE_MAX) begin
                        free_next = free_reg + FREE_W'(1);
                    end
                end
            end
            MODE_QUERY: begin
                if (tail.best_hit) begin
                    res_next.status     = STATUS_OLDEST;
                    res_next.slot_index = tail.best_idx;
                    res_next.found      = tail.best_key;
                end else begin
                    res_next.status = STATUS_NONE_EST;
                end
            end
            default: begin
                res_next.status = STATUS_NOT_FOUND;
            end
        endcase
        res_next.free_slots = free_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (done) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            free_reg    <= FREE_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
            if (done) begin
                free_reg <= free_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg          <= s_mode;
            key_reg.addr_high <= s_key_addr_high;
            key_reg.addr_low  <= s_key_addr_low;
            key_reg.port      <= s_key_port;
            key_reg.netif     <= s_key_netif;
            nst_reg           <= (s_store_state > ST_ESTABLISHED) ? ST_ESTABLISHED
                                                                  : s_store_state;
            now_reg           <= s_time_now;
        end
        if (done) begin
            res_reg <= res_next;
        end
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_previous_state  = out_reg.previous_state;
    assign m_slot_index      = out_reg.slot_index;
    assign m_found_addr_high = out_reg.found.addr_high;
    assign m_found_addr_low  = out_reg.found.addr_low;
    assign m_found_port      = out_reg.found.port;
    assign m_found_netif     = out_reg.found.netif;
    assign m_free_slots      = out_reg.free_slots;

    // at most one search word in the row
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid))
        else $error("more than one search word in flight");

    a_tail_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == S_SEARCH))
        else $error("search word left the row outside search");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FREE_MAX)
        else $error("free count above slot count");

    a_write_once: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> !wr.en)
        else $error("write-back issued twice");

endmodule
